>>> rtl/srgf_pkg.sv
package srgf_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W = 32;
  localparam int TAG_W = 16;
  localparam int GAP_W = 16;
  localparam logic [ID_W-1:0] SPAN_SLACK = 32'd20;
  localparam logic [GAP_W-1:0] MAX_GAP_RST = 16'd10;

  localparam logic [1:0] KIND_ITEM = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

endpackage

>>> rtl/srgf_store.sv
module srgf_store import srgf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IW-1:0]    rd_idx,
  output logic             rd_valid,
  output logic [ID_W-1:0]  rd_id,
  output logic [TAG_W-1:0] rd_tag,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_idx,
  input  logic [ID_W-1:0]  wr_id,
  input  logic [TAG_W-1:0] wr_tag,
  input  logic             clr_en,
  input  logic [IW-1:0]    clr_idx,
  input  logic             clr_all,
  output logic [CW-1:0]    count
);

  logic [DEPTH-1:0] valid;
  logic [ID_W-1:0]  ids [DEPTH];
  logic [TAG_W-1:0] tags [DEPTH];

  assign rd_valid = valid[rd_idx];
  assign rd_id = ids[rd_idx];
  assign rd_tag = tags[rd_idx];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids[wr_idx] <= wr_id;
      tags[wr_idx] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (clr_all) begin
      valid <= '0;
      count <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
      if (!valid[wr_idx]) begin
        count <= count + CW'(1);
      end
    end else if (clr_en) begin
      valid[clr_idx] <= 1'b0;
      count <= count - CW'(1);
    end
  end

endmodule

>>> rtl/sequence_reorder_gap_filler_top.sv
// channel   | direction | signals
// ----------+-----------+----------------------------------------------------
// command   | in        | start, command, seq_id, payload_tag (busy is out)
// result    | out       | result_valid, kind, out_id, out_tag, filler_count, last
// config    | in        | cfg_we, cfg_data (max_gap)
//
// One shared scan over the store visits one entry a cycle. An arrival takes a
// lookup scan, a write, then drain passes (one per emitted item plus one) and
// gap checks (min/max scan, decision); a flush adds a scan, a fill check and
// an item step per entry. A full-store drop goes to finish. Each result is held
// until the next one is made, so last can be set; the final one goes out after
// the last state. Reset clears the store valid bits and expected id at once.
// The receiver cannot stall; busy falls in the cycle that last is on the ports.
module sequence_reorder_gap_filler_top import srgf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             command,
  input  logic [ID_W-1:0]  seq_id,
  input  logic [TAG_W-1:0] payload_tag,
  input  logic             cfg_we,
  input  logic [GAP_W-1:0] cfg_data,
  output logic             result_valid,
  output logic [1:0]       kind,
  output logic [ID_W-1:0]  out_id,
  output logic [TAG_W-1:0] out_tag,
  output logic [ID_W-1:0]  filler_count,
  output logic             last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ASCAN  = 4'd1;
  localparam logic [3:0] S_AWRITE = 4'd2;
  localparam logic [3:0] S_DSCAN  = 4'd3;
  localparam logic [3:0] S_MSCAN  = 4'd4;
  localparam logic [3:0] S_GAP    = 4'd5;
  localparam logic [3:0] S_FFILL  = 4'd6;
  localparam logic [3:0] S_FITEM  = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0]       state;
  logic [IW-1:0]    idx;
  logic [GAP_W-1:0] max_gap;
  logic [ID_W-1:0]  expected;
  logic             cmd_q;
  logic [ID_W-1:0]  id_q;
  logic [TAG_W-1:0] tag_q;
  logic             match_found, free_found;
  logic [IW-1:0]    match_idx, free_idx;
  logic             any;
  logic             fphase;
  logic             have;
  logic [ID_W-1:0]  lo, hi;
  logic [IW-1:0]    lo_idx;

  logic             pend_valid;
  logic [1:0]       pend_kind;
  logic [ID_W-1:0]  pend_id;
  logic [TAG_W-1:0] pend_tag;
  logic [ID_W-1:0]  pend_cnt;

  logic [IW-1:0]    rd_idx;
  logic             rd_valid;
  logic [ID_W-1:0]  rd_id;
  logic [TAG_W-1:0] rd_tag;
  logic             wr_en, clr_en, clr_all;
  logic [IW-1:0]    wr_idx, clr_idx;
  logic [CW-1:0]    count;

  logic             put_en;
  logic [1:0]       put_kind;
  logic [ID_W-1:0]  put_id;
  logic [TAG_W-1:0] put_tag;
  logic [ID_W-1:0]  put_cnt;

  logic             hit, full, gap_jump;
  logic [ID_W-1:0]  d_lo, d_span;

  assign busy = (state != S_IDLE);
  assign full = (count >= CW'(DEPTH));
  assign hit = rd_valid && (rd_id == expected);
  assign d_lo = lo - expected;
  assign d_span = hi - lo;
  assign gap_jump = have && (d_lo > ID_W'(max_gap)) &&
                    (d_span > (ID_W'(max_gap) + SPAN_SLACK));

  assign rd_idx = (state == S_FITEM) ? lo_idx : idx;
  assign wr_en = (state == S_AWRITE);
  assign wr_idx = match_found ? match_idx : free_idx;
  assign clr_en = ((state == S_DSCAN) && hit) || (state == S_FITEM);
  assign clr_idx = rd_idx;
  assign clr_all = (state == S_FINISH) && (cmd_q == CMD_FLUSH);

  srgf_store #(.DEPTH(DEPTH)) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_valid (rd_valid),
    .rd_id    (rd_id),
    .rd_tag   (rd_tag),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_id    (id_q),
    .wr_tag   (tag_q),
    .clr_en   (clr_en),
    .clr_idx  (clr_idx),
    .clr_all  (clr_all),
    .count    (count)
  );

  always_comb begin
    put_en = 1'b0;
    put_kind = KIND_ITEM;
    put_id = rd_id;
    put_tag = '0;
    put_cnt = '0;
    case (state)
      S_IDLE: begin
        put_en = start && (command == CMD_ARRIVE) && full;
        put_kind = KIND_DROP;
        put_id = seq_id;
      end
      S_DSCAN: begin
        put_en = hit;
        put_tag = rd_tag;
      end
      S_GAP: begin
        put_en = gap_jump && (expected < lo);
        put_kind = KIND_FILL;
        put_id = expected;
        put_cnt = d_lo;
      end
      S_FFILL: begin
        // lo is stale once the store is empty
        put_en = have && (expected < lo);
        put_kind = KIND_FILL;
        put_id = expected;
        put_cnt = d_lo;
      end
      S_FITEM: begin
        put_en = 1'b1;
        put_tag = rd_tag;
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  // one result is held back so that last can be set on the final one
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (put_en) begin
        pend_valid <= 1'b1;
        pend_kind <= put_kind;
        pend_id <= put_id;
        pend_tag <= put_tag;
        pend_cnt <= put_cnt;
        result_valid <= pend_valid;
        if (pend_valid) begin
          kind <= pend_kind;
          out_id <= pend_id;
          out_tag <= pend_tag;
          filler_count <= pend_cnt;
          last <= 1'b0;
        end
      end else if (state == S_FINISH) begin
        pend_valid <= 1'b0;
        result_valid <= 1'b1;
        last <= 1'b1;
        if (pend_valid) begin
          kind <= pend_kind;
          out_id <= pend_id;
          out_tag <= pend_tag;
          filler_count <= pend_cnt;
        end else begin
          kind <= KIND_NONE;
          out_id <= '0;
          out_tag <= '0;
          filler_count <= '0;
        end
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= MAX_GAP_RST;
    end else if (cfg_we) begin
      max_gap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      expected <= '0;
      idx <= '0;
      fphase <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= command;
            id_q <= seq_id;
            tag_q <= payload_tag;
            idx <= '0;
            any <= 1'b0;
            fphase <= 1'b0;
            match_found <= 1'b0;
            free_found <= 1'b0;
            if (command == CMD_FLUSH) begin
              state <= S_DSCAN;
            end else if (full) begin
              state <= S_FINISH;
            end else begin
              state <= S_ASCAN;
            end
          end
        end
        S_ASCAN: begin
          if (rd_valid && rd_id == id_q && !match_found) begin
            match_found <= 1'b1;
            match_idx <= idx;
          end
          if (!rd_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx <= idx;
          end
          idx <= idx + IW'(1);
          if (idx == LAST_IDX) begin
            state <= S_AWRITE;
          end
        end
        S_AWRITE: begin
          idx <= '0;
          state <= S_DSCAN;
        end
        S_DSCAN: begin
          if (hit) begin
            expected <= expected + ID_W'(1);
            any <= 1'b1;
            idx <= '0;
          end else if (idx == LAST_IDX) begin
            idx <= '0;
            have <= 1'b0;
            if (any) begin
              state <= S_MSCAN;
            end else if (cmd_q == CMD_FLUSH) begin
              fphase <= 1'b1;
              state <= S_MSCAN;
            end else begin
              state <= S_FINISH;
            end
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_MSCAN: begin
          if (rd_valid) begin
            have <= 1'b1;
            if (!have || rd_id < lo) begin
              lo <= rd_id;
              lo_idx <= idx;
            end
            if (!have || rd_id > hi) begin
              hi <= rd_id;
            end
          end
          if (idx == LAST_IDX) begin
            idx <= '0;
            state <= fphase ? S_FFILL : S_GAP;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_GAP: begin
          if (gap_jump) begin
            expected <= lo;
            any <= 1'b0;
            idx <= '0;
            state <= S_DSCAN;
          end else if (cmd_q == CMD_FLUSH) begin
            fphase <= 1'b1;
            have <= 1'b0;
            idx <= '0;
            state <= S_MSCAN;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FFILL: begin
          // empty store ends the flush
          state <= have ? S_FITEM : S_FINISH;
        end
        S_FITEM: begin
          expected <= lo + ID_W'(1);
          have <= 1'b0;
          idx <= '0;
          state <= S_MSCAN;
        end
        S_FINISH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
